// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the tone curve RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define PTC_ASSERT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define PTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define PTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ptc_pkg.sv =====
// Package of the tone curve core: sizes, register indexes, reset values,
// stage payload types and the division step. Depends on nothing.
package ptc_pkg;

  localparam int KNOT_COUNT = 6;
  localparam int KNOT_W     = 8;
  localparam int REG_W      = KNOT_W * KNOT_COUNT;
  localparam int PROD_W     = 2 * KNOT_W;

  // Divider: two quotient bits per stage
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = KNOT_W / DIV_BITS;
  // Segment stage, product stage, divider stages, output stage
  localparam int NUM_STAGES = DIV_STAGES + 3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_IN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_OUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_OUT = 2'd2;

  // Reset curves, knot 0 in the low byte
  localparam logic [63:0] RESET_KNOT_IN  = 64'h0000_FFC8_9664_3200;
  localparam logic [63:0] RESET_RED_OUT  = 64'h0000_FFDC_BE96_5000;
  localparam logic [63:0] RESET_BLUE_OUT = 64'h0000_FF96_4B28_1400;

  typedef struct packed {
    logic [REG_W-1:0] knot_x;
    logic [REG_W-1:0] red_y;
    logic [REG_W-1:0] blue_y;
  } cfg_t;

  // Selected segment: result = y0 +/- dy_mag * dn / dx
  typedef struct packed {
    logic [KNOT_W-1:0] y0;
    logic              dy_neg;
    logic [KNOT_W-1:0] dy_mag;
    logic [KNOT_W-1:0] dn;
    logic [KNOT_W-1:0] dx;
  } seg_t;

  typedef struct packed {
    logic [KNOT_W-1:0] y0;
    logic              dy_neg;
    logic [PROD_W-1:0] num;
    logic [KNOT_W-1:0] den;
  } prod_t;

  typedef struct packed {
    logic [KNOT_W-1:0] y0;
    logic              neg;
    logic [KNOT_W-1:0] rem;
    logic [KNOT_W-1:0] low;
    logic [KNOT_W-1:0] quo;
    logic [KNOT_W-1:0] den;
  } div_t;

  // One restoring division step: bring down a numerator bit, subtract if it fits
  function automatic div_t div_step(div_t d);
    div_t              res;
    logic [KNOT_W:0]   r;
    logic              qb;
    res = d;
    r   = {d.rem, d.low[KNOT_W-1]};
    qb  = 1'b0;
    if (r >= {1'b0, d.den}) begin
      r  = r - {1'b0, d.den};
      qb = 1'b1;
    end
    res.rem = r[KNOT_W-1:0];
    res.low = {d.low[KNOT_W-2:0], 1'b0};
    res.quo = {d.quo[KNOT_W-2:0], qb};
    return res;
  endfunction

  // The steps of one divider stage
  function automatic div_t div_stage(div_t d);
    div_t res;
    res = d;
    for (int b = 0; b < DIV_BITS; b++) begin
      res = div_step(res);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/ptc_pix_if.sv =====
// Pixel stream interfaces of the tone curve core, input and output side.
// Depends on ptc_pkg for the sample width.
interface ptc_pix_in_if;
  logic                      valid;
  logic                      ready;
  logic [ptc_pkg::KNOT_W-1:0] red_in;
  logic [ptc_pkg::KNOT_W-1:0] green_in;
  logic [ptc_pkg::KNOT_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface ptc_pix_out_if;
  logic                      valid;
  logic                      ready;
  logic [ptc_pkg::KNOT_W-1:0] red_out;
  logic [ptc_pkg::KNOT_W-1:0] green_out;
  logic [ptc_pkg::KNOT_W-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

// ===== rtl/core/ptc_cfg_regs.sv =====
// Curve configuration registers: shared knot inputs, red and blue knot outputs.
// Depends on ptc_pkg.
module ptc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ptc_pkg::REG_W-1:0]      cfg_wdata_i,
  output ptc_pkg::cfg_t                  cfg_o
);
  import ptc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KNOT_IN:  cfg_d.knot_x = cfg_wdata_i;
        REG_RED_OUT:  cfg_d.red_y  = cfg_wdata_i;
        REG_BLUE_OUT: cfg_d.blue_y = cfg_wdata_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.knot_x <= RESET_KNOT_IN[REG_W-1:0];
      cfg_q.red_y  <= RESET_RED_OUT[REG_W-1:0];
      cfg_q.blue_y <= RESET_BLUE_OUT[REG_W-1:0];
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/ptc_seg_sel.sv =====
// Segment search for one colour: first knot at or above the sample, then the
// operands of the interpolation. Depends on ptc_pkg.
module ptc_seg_sel (
  input  logic [ptc_pkg::KNOT_W-1:0] sample_i,
  input  logic [ptc_pkg::REG_W-1:0]  knot_x_i,
  input  logic [ptc_pkg::REG_W-1:0]  knot_y_i,
  output ptc_pkg::seg_t              seg_o
);
  import ptc_pkg::*;

  logic [KNOT_W-1:0] x  [KNOT_COUNT];
  logic [KNOT_W-1:0] y  [KNOT_COUNT];
  logic [KNOT_W-1:0] xp [KNOT_COUNT];
  logic [KNOT_W-1:0] yp [KNOT_COUNT];

  // Unpack the knots and their left neighbours
  always_comb begin
    for (int k = 0; k < KNOT_COUNT; k++) begin
      x[k] = knot_x_i[k*KNOT_W +: KNOT_W];
      y[k] = knot_y_i[k*KNOT_W +: KNOT_W];
    end
    xp[0] = '0;
    yp[0] = '0;
    for (int k = 1; k < KNOT_COUNT; k++) begin
      xp[k] = x[k-1];
      yp[k] = y[k-1];
    end
  end

  // Pick the first knot at or above the sample; exact hits and the first knot
  // give the knot output directly, no hit saturates to the last output
  always_comb begin
    logic found;
    found        = 1'b0;
    seg_o.y0     = y[KNOT_COUNT-1];
    seg_o.dy_neg = 1'b0;
    seg_o.dy_mag = '0;
    seg_o.dn     = '0;
    seg_o.dx     = KNOT_W'(1);
    for (int k = 0; k < KNOT_COUNT; k++) begin
      if (!found && (x[k] >= sample_i)) begin
        found = 1'b1;
        if ((x[k] == sample_i) || (k == 0)) begin
          seg_o.y0 = y[k];
        end else begin
          seg_o.y0     = yp[k];
          seg_o.dy_neg = (y[k] < yp[k]);
          seg_o.dy_mag = (y[k] < yp[k]) ? (yp[k] - y[k]) : (y[k] - yp[k]);
          seg_o.dn     = sample_i - xp[k];
          seg_o.dx     = x[k] - xp[k];
        end
      end
    end
  end

endmodule

// ===== rtl/core/ptc_lerp_pipe.sv =====
// Interpolation datapath of one colour: segment register, product, pipelined
// restoring divider and the final add and clamp. Depends on ptc_pkg.
module ptc_lerp_pipe (
  input  logic                            clk_i,
  input  logic [ptc_pkg::NUM_STAGES-1:0]  en_i,
  input  ptc_pkg::seg_t                   seg_i,
  output logic [ptc_pkg::KNOT_W-1:0]      res_o
);
  import ptc_pkg::*;

  seg_t              seg_q;
  prod_t             prod_q, prod_d;
  div_t              div_q [DIV_STAGES];
  div_t              div_init;
  logic [KNOT_W+1:0] sum;
  logic [KNOT_W+1:0] quo_s;
  logic [KNOT_W-1:0] res_d, res_q;

  // Scale the slope numerator by the offset into the segment
  always_comb begin
    prod_d.y0     = seg_q.y0;
    prod_d.dy_neg = seg_q.dy_neg;
    prod_d.num    = PROD_W'(seg_q.dy_mag) * PROD_W'(seg_q.dn);
    prod_d.den    = seg_q.dx;
  end

  // The high byte of the product stays below the divisor, so it seeds the
  // partial remainder and the quotient fits in one byte
  always_comb begin
    div_init.y0  = prod_q.y0;
    div_init.neg = prod_q.dy_neg;
    div_init.rem = prod_q.num[PROD_W-1:KNOT_W];
    div_init.low = prod_q.num[KNOT_W-1:0];
    div_init.quo = '0;
    div_init.den = prod_q.den;
  end

  // Apply the sign of the slope and clamp to the sample range
  always_comb begin
    quo_s = {2'b00, div_q[DIV_STAGES-1].quo};
    if (div_q[DIV_STAGES-1].neg) begin
      quo_s = -quo_s;
    end
    sum = {2'b00, div_q[DIV_STAGES-1].y0} + quo_s;
    if (sum[KNOT_W+1]) begin
      res_d = '0;
    end else if (sum[KNOT_W]) begin
      res_d = {KNOT_W{1'b1}};
    end else begin
      res_d = sum[KNOT_W-1:0];
    end
  end

  // Advance each stage when the control says it may load
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      seg_q <= seg_i;
    end
    if (en_i[1]) begin
      prod_q <= prod_d;
    end
    if (en_i[2]) begin
      div_q[0] <= div_stage(div_init);
    end
    for (int i = 1; i < DIV_STAGES; i++) begin
      if (en_i[i+2]) begin
        div_q[i] <= div_stage(div_q[i-1]);
      end
    end
    if (en_i[NUM_STAGES-1]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/piecewise_linear_tone_curve_core.sv =====
// Top level of the tone curve core: stream control, green delay line and the
// red and blue curve datapaths. Depends on ptc_pkg, ptc_pix_if, ptc_cfg_regs,
// ptc_seg_sel, ptc_lerp_pipe and assert_macros.svh.
//
// One RGB pixel per clock goes in and one comes out while the output is ready,
// through a segment search stage, an 8x8 multiply stage, four divider stages
// at two quotient bits each and an output register. Red and blue follow six-knot
// piecewise-linear curves set through the configuration port (index 0 knot
// inputs, 1 red outputs, 2 blue outputs, knot 0 in the low byte); green passes
// unchanged. Each stage carries a valid bit and stalls only when it holds data
// and the stage after it cannot load, so empty stages are filled while the
// output waits. Write the registers only while no pixel is in flight.
`include "assert_macros.svh"

module piecewise_linear_tone_curve_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ptc_pkg::REG_W-1:0]      cfg_wdata_i,
  ptc_pix_in_if.sink                     pix_i,
  ptc_pix_out_if.source                  pix_o
);
  import ptc_pkg::*;

  cfg_t                  cfg;
  seg_t                  red_seg, blue_seg;
  logic [NUM_STAGES-1:0] v_q, v_d, v_in, en;
  logic [NUM_STAGES:0]   rdy;
  logic [KNOT_W-1:0]     green_q [NUM_STAGES];
  logic                  in_acc;
  logic                  full_stall;

  ptc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ptc_seg_sel u_red_sel (
    .sample_i (pix_i.red_in),
    .knot_x_i (cfg.knot_x),
    .knot_y_i (cfg.red_y),
    .seg_o    (red_seg)
  );

  ptc_seg_sel u_blue_sel (
    .sample_i (pix_i.blue_in),
    .knot_x_i (cfg.knot_x),
    .knot_y_i (cfg.blue_y),
    .seg_o    (blue_seg)
  );

  // Ready ripples back: a stage may load when it is empty or its data moves on
  always_comb begin
    rdy[NUM_STAGES] = pix_o.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign en   = rdy[NUM_STAGES-1:0];
  assign v_in = {v_q[NUM_STAGES-2:0], pix_i.valid};
  assign v_d  = (en & v_in) | (~en & v_q);

  // Hold the valid bits of the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Delay green alongside the curve datapaths
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      green_q[0] <= pix_i.green_in;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        green_q[k] <= green_q[k-1];
      end
    end
  end

  ptc_lerp_pipe u_red_pipe (
    .clk_i (clk_i),
    .en_i  (en),
    .seg_i (red_seg),
    .res_o (pix_o.red_out)
  );

  ptc_lerp_pipe u_blue_pipe (
    .clk_i (clk_i),
    .en_i  (en),
    .seg_i (blue_seg),
    .res_o (pix_o.blue_out)
  );

  assign pix_i.ready     = rdy[0];
  assign pix_o.valid     = v_q[NUM_STAGES-1];
  assign pix_o.green_out = green_q[NUM_STAGES-1];

  assign in_acc     = pix_i.valid && pix_i.ready;
  assign full_stall = (&v_q) && !pix_o.ready;

  // An empty stage anywhere lets a new transaction in
  `PTC_ASSERT_IMP(a_ready_when_gap, clk_i, rst_ni, !(&v_q), pix_i.ready, "stalled with free stage")
  // A full pipe behind a stalled output takes nothing
  `PTC_ASSERT_IMP(a_block_full, clk_i, rst_ni, full_stall, !pix_i.ready, "full pipe took input")
  // An accepted transaction occupies the first stage next cycle
  `PTC_ASSERT_NXT(a_accept_lands, clk_i, rst_ni, in_acc, v_q[0], "accepted transaction lost")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench of piecewise_linear_tone_curve_core: random and directed pixels checked against
// its own model of the red and blue curves. Depends on ptc_pkg and ptc_pix_if from the RTL.

import ptc_pkg::*;

typedef struct packed {
  logic [KNOT_W-1:0] red;
  logic [KNOT_W-1:0] green;
  logic [KNOT_W-1:0] blue;
} pixel_t;

typedef enum {RX_OPEN, RX_PATTERN, RX_RANDOM} rx_mode_e;

// Curve model plus the queue of pixels still owed by the core
class tone_curve_scoreboard;
  logic [REG_W-1:0] knot_x;
  logic [REG_W-1:0] red_y;
  logic [REG_W-1:0] blue_y;
  pixel_t           owed_q[$];
  int               errors;
  int               checked;

  function new();
    knot_x  = RESET_KNOT_IN[REG_W-1:0];
    red_y   = RESET_RED_OUT[REG_W-1:0];
    blue_y  = RESET_BLUE_OUT[REG_W-1:0];
    errors  = 0;
    checked = 0;
  endfunction

  // Mirror a register write; unused indexes leave the curves alone
  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
    case (idx)
      REG_KNOT_IN:  knot_x = data;
      REG_RED_OUT:  red_y  = data;
      REG_BLUE_OUT: blue_y = data;
      default: ;
    endcase
  endfunction

  // First knot at or above the sample ends the segment; interpolate with truncation
  function logic [KNOT_W-1:0] curve_lookup(logic [KNOT_W-1:0] sample, logic [REG_W-1:0] ys);
    int s, seg, x0, x1, y0, y1, v;
    s   = int'(sample);
    seg = KNOT_COUNT;
    for (int k = KNOT_COUNT - 1; k >= 0; k--) begin
      if (int'(knot_x[KNOT_W*k +: KNOT_W]) >= s) seg = k;
    end
    // Above the last knot: saturate to its output
    if (seg == KNOT_COUNT) return ys[KNOT_W*(KNOT_COUNT-1) +: KNOT_W];
    x1 = int'(knot_x[KNOT_W*seg +: KNOT_W]);
    y1 = int'(ys[KNOT_W*seg +: KNOT_W]);
    // Exact knot, or below the first knot
    if (x1 == s || seg == 0) return y1[KNOT_W-1:0];
    x0 = int'(knot_x[KNOT_W*(seg-1) +: KNOT_W]);
    y0 = int'(ys[KNOT_W*(seg-1) +: KNOT_W]);
    v  = y0 + ((y1 - y0) * (s - x0)) / (x1 - x0);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[KNOT_W-1:0];
  endfunction

  function void note_pixel(pixel_t px);
    pixel_t exp_px;
    exp_px.red   = curve_lookup(px.red, red_y);
    exp_px.green = px.green;
    exp_px.blue  = curve_lookup(px.blue, blue_y);
    owed_q.push_back(exp_px);
  endfunction

  function void report(string what, logic [KNOT_W-1:0] exp_v, logic [KNOT_W-1:0] act_v);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
  endfunction

  function void check_pixel(pixel_t px);
    pixel_t exp_px;
    if (owed_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected output pixel, expected none, got %0d/%0d/%0d",
               $time, px.red, px.green, px.blue);
      return;
    end
    exp_px = owed_q.pop_front();
    checked++;
    if (px.red !== exp_px.red) report("red", exp_px.red, px.red);
    if (px.green !== exp_px.green) report("green", exp_px.green, px.green);
    if (px.blue !== exp_px.blue) report("blue", exp_px.blue, px.blue);
  endfunction

  function int pending();
    return owed_q.size();
  endfunction
endclass

module tb;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [REG_W-1:0]     cfg_wdata_i;

  ptc_pix_in_if  pix_in ();
  ptc_pix_out_if pix_out ();

  tone_curve_scoreboard sb = new();

  rx_mode_e   rx_mode    = RX_OPEN;
  logic [7:0] rx_pattern = 8'hFF;
  int         rx_hold    = 0;
  bit         tx_gaps    = 1'b1;
  int         pixels_sent = 0;
  int         settings_run = 0;

  piecewise_linear_tone_curve_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_in),
    .pix_o       (pix_out)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Give up after a generous fixed time
  initial begin
    #200000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: stall on a rotating pattern, at random, or not at all
  always @(negedge clk_i) begin
    case (rx_mode)
      RX_OPEN: pix_out.ready = 1'b1;
      RX_PATTERN: begin
        pix_out.ready = rx_pattern[0];
        rx_pattern    = {rx_pattern[0], rx_pattern[7:1]};
      end
      default: begin
        if (rx_hold > 0) begin
          pix_out.ready = 1'b0;
          rx_hold--;
        end else if ($urandom_range(0, 15) == 0) begin
          pix_out.ready = 1'b0;
          rx_hold       = int'($urandom_range(1, 12));
        end else begin
          pix_out.ready = ($urandom_range(0, 3) != 0);
        end
      end
    endcase
  end

  // Note each input transaction and check each output transaction
  always @(posedge clk_i) begin
    if (rst_ni && pix_in.valid && pix_in.ready)
      sb.note_pixel('{pix_in.red_in, pix_in.green_in, pix_in.blue_in});
    if (rst_ni && pix_out.valid && pix_out.ready)
      sb.check_pixel('{pix_out.red_out, pix_out.green_out, pix_out.blue_out});
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic write_curves(logic [REG_W-1:0] xs, logic [REG_W-1:0] rs,
                              logic [REG_W-1:0] bs);
    write_reg(REG_KNOT_IN, xs);
    write_reg(REG_RED_OUT, rs);
    write_reg(REG_BLUE_OUT, bs);
    settings_run++;
  endtask

  // Present one pixel and hold it until the core takes it
  task automatic send_pixel(pixel_t px);
    @(negedge clk_i);
    pix_in.valid    = 1'b1;
    pix_in.red_in   = px.red;
    pix_in.green_in = px.green;
    pix_in.blue_in  = px.blue;
    do @(posedge clk_i); while (!pix_in.ready);
    pixels_sent++;
  endtask

  task automatic idle_input(int cycles);
    @(negedge clk_i);
    pix_in.valid = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Wait until every owed pixel has come out
  task automatic drain();
    idle_input(1);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [REG_W-1:0] rand_reg();
    return REG_W'({$urandom(), $urandom()});
  endfunction

  // Random knot positions in ascending order, repeats allowed
  function automatic logic [REG_W-1:0] sorted_knots();
    logic [REG_W-1:0] xs;
    byte unsigned     kv[KNOT_COUNT];
    foreach (kv[k]) kv[k] = 8'($urandom_range(0, 255));
    kv.sort();
    foreach (kv[k]) xs[KNOT_W*k +: KNOT_W] = kv[k];
    return xs;
  endfunction

  // Favour knot positions, their neighbours and the ends of the range
  function automatic logic [KNOT_W-1:0] pick_sample();
    logic [KNOT_W-1:0] knot;
    knot = sb.knot_x[KNOT_W*$urandom_range(0, KNOT_COUNT-1) +: KNOT_W];
    case ($urandom_range(0, 9))
      0, 1:    return knot;
      2:       return ($urandom_range(0, 1) != 0) ? knot + 8'd1 : knot - 8'd1;
      3:       return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      default: return KNOT_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Random pixels in bursts, with random gaps when asked, then drain
  task automatic run_phase(int count, rx_mode_e mode, bit gaps);
    int burst;
    burst      = 0;
    rx_mode    = mode;
    rx_pattern = 8'($urandom_range(1, 255));
    tx_gaps    = gaps;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        if (tx_gaps && $urandom_range(0, 2) != 0) idle_input($urandom_range(1, 6));
        burst = $urandom_range(1, 24);
      end
      send_pixel('{pick_sample(), 8'($urandom_range(0, 255)), pick_sample()});
      burst--;
    end
    drain();
  endtask

  initial begin
    logic [REG_W-1:0] alt;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_KNOT_IN;
    cfg_wdata_i     = '0;
    pix_in.valid    = 1'b0;
    pix_in.red_in   = '0;
    pix_in.green_in = '0;
    pix_in.blue_in  = '0;
    pix_out.ready   = 1'b0;
    rst_ni          = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset curves: ends, exact knots, neighbours of knots
    rx_mode = RX_RANDOM;
    settings_run++;
    send_pixel('{8'd0, 8'd0, 8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255});
    send_pixel('{8'd1, 8'h55, 8'd254});
    send_pixel('{8'd50, 8'hAA, 8'd100});
    send_pixel('{8'd49, 8'h0F, 8'd51});
    send_pixel('{8'd150, 8'hF0, 8'd200});
    send_pixel('{8'd199, 8'h81, 8'd201});
    send_pixel('{8'd128, 8'h7E, 8'd25});
    send_pixel('{8'd254, 8'h01, 8'd149});
    drain();

    // All knots at zero: everything above zero lies past the last knot
    write_curves('0, 48'hFF_80_60_40_20_10, 48'h05_04_03_02_01_FF);
    send_pixel('{8'd0, 8'd1, 8'd0});
    send_pixel('{8'd1, 8'd2, 8'd255});
    send_pixel('{8'd255, 8'd4, 8'd128});
    drain();

    // All knots at full scale: everything below lies under the first knot
    write_curves('1, 48'h00_11_22_33_44_FF, 48'h99_88_77_66_55_00);
    send_pixel('{8'd0, 8'd8, 8'd254});
    send_pixel('{8'd254, 8'd16, 8'd0});
    send_pixel('{8'd255, 8'd32, 8'd255});
    drain();

    // Rising red outputs, alternating blue outputs, unsorted knots, and an unused index write
    write_curves(48'h40_10_F0_80_20_60, 48'hFF_C0_80_40_10_00, 48'h00_FF_00_FF_00_FF);
    write_reg(REG_UNUSED, rand_reg());
    send_pixel('{8'd16, 8'd64, 8'd90});
    send_pixel('{8'd200, 8'd128, 8'd17});
    send_pixel('{8'd97, 8'd192, 8'd250});
    drain();

    // Random part
    write_curves(RESET_KNOT_IN[REG_W-1:0], RESET_RED_OUT[REG_W-1:0],
                 RESET_BLUE_OUT[REG_W-1:0]);
    run_phase(120, RX_RANDOM, 1'b1);

    write_curves(sorted_knots(), rand_reg(), rand_reg());
    run_phase(120, RX_PATTERN, 1'b1);

    write_curves(rand_reg(), rand_reg(), rand_reg());
    write_reg(REG_UNUSED, rand_reg());
    run_phase(120, RX_RANDOM, 1'b1);

    // Steep segments with outputs swinging between the rails
    alt = 48'hFF_00_FF_00_FF_00;
    write_curves(48'hFF_FE_FD_02_01_00, alt, ~alt);
    run_phase(100, RX_PATTERN, 1'b1);

    write_curves(sorted_knots(), 48'h00_20_60_A0_E0_FF, rand_reg());
    run_phase(100, RX_RANDOM, 1'b0);

    write_curves('0, '1, '0);
    run_phase(60, RX_PATTERN, 1'b1);

    write_curves('1, rand_reg(), rand_reg());
    run_phase(60, RX_RANDOM, 1'b1);

    // Back to the defaults at full rate
    write_curves(RESET_KNOT_IN[REG_W-1:0], RESET_RED_OUT[REG_W-1:0],
                 RESET_BLUE_OUT[REG_W-1:0]);
    run_phase(100, RX_OPEN, 1'b0);

    // Let any stray output show up before closing
    repeat (NUM_STAGES + 8) @(posedge clk_i);

    $display("Summary: %0d pixels over %0d curve settings, %0d output pixels checked.",
             pixels_sent, settings_run, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ptc_pkg.sv
rtl/core/ptc_pix_if.sv
rtl/core/ptc_cfg_regs.sv
rtl/core/ptc_seg_sel.sv
rtl/core/ptc_lerp_pipe.sv
rtl/core/piecewise_linear_tone_curve_core.sv
sim/tb.sv
